// File: rtl/core/b7tcu_pkg.sv
// Shared constants and types of the base-7 terminated code unpacker.
`timescale 1ns / 1ps

package b7tcu_pkg;

  // Field widths.
  localparam int WORD_W  = 32;
  localparam int DIGIT_W = 3;
  localparam int LEFT_W  = 2;

  // Digits per word: the first word of a group has ten, the others eleven.
  localparam int MAX_DIGITS   = 11;
  localparam int FIRST_DIGITS = 10;
  localparam int SHIFT_W      = MAX_DIGITS * DIGIT_W;
  localparam int COUNT_W      = 4;

  // The digit that ends a number.
  localparam logic [DIGIT_W-1:0] TERM_DIGIT = 3'd7;

  // Position of a word in its group of three.
  localparam logic [1:0] PHASE_0 = 2'd0;
  localparam logic [1:0] PHASE_1 = 2'd1;
  localparam logic [1:0] PHASE_2 = 2'd2;

  // One digit as presented by the shifter to the accumulator.
  typedef struct packed {
    logic               valid;
    logic [DIGIT_W-1:0] digit;
    logic               is_term;
    logic               last_term;
    logic               end_of_word;
    logic               clear_after;
  } digit_step_t;

endpackage

// File: rtl/core/b7tcu_digit_shifter.sv
// Word loader and digit shift register with group phase and carried bits.
`timescale 1ns / 1ps

module b7tcu_digit_shifter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [b7tcu_pkg::WORD_W-1:0]   stream_word,
  input  logic                           last_word,
  input  logic                           advance,
  output b7tcu_pkg::digit_step_t         step
);

  logic                                busy;
  logic [b7tcu_pkg::COUNT_W-1:0]       count;
  logic [b7tcu_pkg::SHIFT_W-1:0]       data;
  logic [b7tcu_pkg::MAX_DIGITS-1:0]    term;
  logic                                last_flag;
  logic [1:0]                          phase;
  logic [b7tcu_pkg::LEFT_W-1:0]        leftover;

  logic [b7tcu_pkg::WORD_W+1:0]        wide_bits;
  logic [b7tcu_pkg::SHIFT_W-1:0]       load_data;
  logic [b7tcu_pkg::COUNT_W-1:0]       load_count;
  logic [b7tcu_pkg::MAX_DIGITS-1:0]    load_term;
  logic [1:0]                          phase_next;
  logic [b7tcu_pkg::LEFT_W-1:0]        leftover_next;
  logic                                in_take;

  assign in_stall = busy;
  assign in_take  = in_valid && !busy;

  // Place the word above the bits carried from the previous word of the group.
  always_comb begin
    wide_bits = {stream_word, leftover};
    case (phase)
      b7tcu_pkg::PHASE_1: begin
        load_data     = wide_bits[b7tcu_pkg::SHIFT_W-1:0];
        load_count    = b7tcu_pkg::COUNT_W'(b7tcu_pkg::MAX_DIGITS);
        phase_next    = b7tcu_pkg::PHASE_2;
        leftover_next = {1'b0, stream_word[b7tcu_pkg::WORD_W-1]};
      end
      b7tcu_pkg::PHASE_2: begin
        load_data     = {stream_word, leftover[0]};
        load_count    = b7tcu_pkg::COUNT_W'(b7tcu_pkg::MAX_DIGITS);
        phase_next    = b7tcu_pkg::PHASE_0;
        leftover_next = '0;
      end
      default: begin
        load_data     = {1'b0, stream_word};
        load_count    = b7tcu_pkg::COUNT_W'(b7tcu_pkg::FIRST_DIGITS);
        phase_next    = b7tcu_pkg::PHASE_1;
        leftover_next = stream_word[b7tcu_pkg::WORD_W-1 -: b7tcu_pkg::LEFT_W];
      end
    endcase
  end

  // Mark the terminator positions among the digits this word really holds.
  always_comb begin
    for (int i = 0; i < b7tcu_pkg::MAX_DIGITS; i++) begin
      load_term[i] = (load_data[i*b7tcu_pkg::DIGIT_W +: b7tcu_pkg::DIGIT_W] ==
                      b7tcu_pkg::TERM_DIGIT) &&
                     (b7tcu_pkg::COUNT_W'(i) < load_count);
    end
  end

  // Load on a transfer, then shift one digit out per advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      count    <= '0;
      phase    <= b7tcu_pkg::PHASE_0;
      leftover <= '0;
    end else if (in_take) begin
      busy     <= 1'b1;
      count    <= load_count;
      phase    <= last_word ? b7tcu_pkg::PHASE_0 : phase_next;
      leftover <= last_word ? '0 : leftover_next;
    end else if (advance) begin
      count <= count - 1'b1;
      if (count == b7tcu_pkg::COUNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Digit and terminator shift lines carry no control meaning of their own.
  always_ff @(posedge clk) begin
    if (in_take) begin
      data      <= load_data;
      term      <= load_term;
      last_flag <= last_word;
    end else if (advance) begin
      data <= data >> b7tcu_pkg::DIGIT_W;
      term <= term >> 1;
    end
  end

  // The digit at the bottom of the shift line goes to the accumulator.
  always_comb begin
    step.valid       = busy;
    step.digit       = data[b7tcu_pkg::DIGIT_W-1:0];
    step.is_term     = term[0];
    step.last_term   = (term[b7tcu_pkg::MAX_DIGITS-1:1] == '0);
    step.end_of_word = (count == b7tcu_pkg::COUNT_W'(1));
    step.clear_after = last_flag;
  end

endmodule

// File: rtl/core/b7tcu_accum.sv
// Base-7 accumulator and output register for completed values.
`timescale 1ns / 1ps

module b7tcu_accum (
  input  logic                           clk,
  input  logic                           rst,
  input  b7tcu_pkg::digit_step_t         step,
  output logic                           advance,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [b7tcu_pkg::WORD_W-1:0]   decoded_value,
  output logic                           last_in_word
);

  logic [b7tcu_pkg::WORD_W-1:0] acc;
  logic [b7tcu_pkg::WORD_W-1:0] acc_next;
  logic                         out_free;

  // A terminator waits until the output register can take its value.
  assign out_free = !out_valid || !out_stall;
  assign advance  = step.valid && (!step.is_term || out_free);

  // acc * 7 + d + 1, as an eight-fold shift minus the old value; cleared on a terminator or at the end of a final word.
  always_comb begin
    if (step.is_term || (step.end_of_word && step.clear_after)) begin
      acc_next = '0;
    end else begin
      acc_next = (acc << 3) - acc +
                 b7tcu_pkg::WORD_W'(step.digit) + b7tcu_pkg::WORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (advance) begin
      acc <= acc_next;
    end
  end

  // Output register holds one completed value until its transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step.is_term) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.is_term) begin
      decoded_value <= acc;
      last_in_word  <= step.last_term;
    end
  end

endmodule

// File: rtl/core/base7_terminated_code_unpacker.sv
// Top level of the base-7 terminated code unpacker.
//
//   Channel  Fields                        Handshake
//   input    stream_word, last_word        in_valid / in_stall
//   output   decoded_value, last_in_word   out_valid / out_stall
//
// A word is taken and then shifted out one 3-bit digit per cycle while no
// terminator waits: 10 digits for the first word of a group, 11 for the
// others. The digit shift register sets that pace.
// A terminator waits while the output register is full and stalled.
// Reset clears the accumulator, the carried bits and the group position.
`timescale 1ns / 1ps

module base7_terminated_code_unpacker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [b7tcu_pkg::WORD_W-1:0]   stream_word,
  input  logic                           last_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [b7tcu_pkg::WORD_W-1:0]   decoded_value,
  output logic                           last_in_word
);

  b7tcu_pkg::digit_step_t step;
  logic                   advance;

  // Digit source.
  b7tcu_digit_shifter u_shifter (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stream_word (stream_word),
    .last_word   (last_word),
    .advance     (advance),
    .step        (step)
  );

  // Value builder and result register.
  b7tcu_accum u_accum (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .decoded_value (decoded_value),
    .last_in_word  (last_in_word)
  );

endmodule

// File: bench/tb_base7_terminated_code_unpacker.sv
// Self-checking testbench for the base-7 terminated code unpacker.
`timescale 1ns / 1ps

module tb_base7_terminated_code_unpacker;

  localparam int BASE        = 7;
  localparam int SETTLE_CYC  = 16;
  localparam int RAND_WORDS  = 88;
  localparam int TIMEOUT_NS  = 8_000_000;
  localparam int LAST_PCT    = 4;

  // One decoded number as the block should present it.
  typedef struct {
    logic [b7tcu_pkg::WORD_W-1:0] value;
    logic                         last;
  } decoded_t;

  // Tracks the decoder state and the numbers still owed by the block.
  class value_board;
    decoded_t                     owed_values[$];
    logic [b7tcu_pkg::WORD_W-1:0] acc;
    logic [b7tcu_pkg::LEFT_W-1:0] carry;
    logic [1:0]                   phase;
    int                           errors;

    function new();
      acc    = '0;
      carry  = '0;
      phase  = b7tcu_pkg::PHASE_0;
      errors = 0;
    endfunction

    // Decode one accepted word and queue the numbers it completes.
    function void note_word(logic [b7tcu_pkg::WORD_W-1:0] word, logic last);
      logic [b7tcu_pkg::WORD_W+1:0]  bits;
      logic [b7tcu_pkg::DIGIT_W-1:0] d;
      logic [1:0]                    next_phase;
      int                            ndig;
      decoded_t                      found[$];
      decoded_t                      item;
      case (phase)
        b7tcu_pkg::PHASE_1: begin
          bits       = {word, carry};
          ndig       = b7tcu_pkg::MAX_DIGITS;
          next_phase = b7tcu_pkg::PHASE_2;
        end
        b7tcu_pkg::PHASE_2: begin
          bits       = {1'b0, word, carry[0]};
          ndig       = b7tcu_pkg::MAX_DIGITS;
          next_phase = b7tcu_pkg::PHASE_0;
        end
        default: begin
          // A new group ignores whatever bits were carried.
          bits       = {2'b00, word};
          ndig       = b7tcu_pkg::FIRST_DIGITS;
          next_phase = b7tcu_pkg::PHASE_1;
        end
      endcase
      for (int k = 0; k < ndig; k++) begin
        d = bits[b7tcu_pkg::DIGIT_W-1:0];
        if (d == b7tcu_pkg::TERM_DIGIT) begin
          item.value = acc;
          item.last  = 1'b0;
          found.push_back(item);
          acc = '0;
        end else begin
          acc = acc * BASE + b7tcu_pkg::WORD_W'(d) + 1;
        end
        bits = bits >> b7tcu_pkg::DIGIT_W;
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[k]) owed_values.push_back(found[k]);
      carry = bits[b7tcu_pkg::LEFT_W-1:0];
      phase = next_phase;
      // The final word drops any partial number and restarts the group.
      if (last) begin
        acc   = '0;
        carry = '0;
        phase = b7tcu_pkg::PHASE_0;
      end
    endfunction

    // Compare one output transfer with the oldest owed number.
    function void check_value(logic [b7tcu_pkg::WORD_W-1:0] value, logic last);
      decoded_t want;
      if (owed_values.size() == 0) begin
        $error("unexpected result: decoded_value=%0h last_in_word=%0b", value, last);
        errors++;
        return;
      end
      want = owed_values.pop_front();
      if (value !== want.value) begin
        $error("decoded_value: expected %0h, got %0h", want.value, value);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_in_word: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int owed_count();
      return owed_values.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst         = 1'b1;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic [b7tcu_pkg::WORD_W-1:0] stream_word = '0;
  logic                         last_word   = 1'b0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic [b7tcu_pkg::WORD_W-1:0] decoded_value;
  logic                         last_in_word;

  value_board board;
  int         idle_pct  = 0;
  int         stall_pct = 0;

  base7_terminated_code_unpacker u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .stream_word   (stream_word),
    .last_word     (last_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .decoded_value (decoded_value),
    .last_in_word  (last_in_word)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Random receiver back-pressure.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Check every output transfer.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_value(decoded_value, last_in_word);
  end

  // Offer one word, with random idle cycles ahead of it, until it transfers.
  task automatic send_word(input logic [b7tcu_pkg::WORD_W-1:0] word, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    stream_word <= word;
    last_word   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(word, last);
    @(negedge clk);
  endtask

  // Hold the sender off until all owed numbers are out, then switch idling and stalling.
  task automatic drain(input int next_idle, input int next_stall);
    in_valid <= 1'b0;
    while (board.owed_count() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    idle_pct  = next_idle;
    stall_pct = next_stall;
    @(negedge clk);
  endtask

  // Fully random words, or words built from digits with a chosen density of terminators.
  function automatic logic [b7tcu_pkg::WORD_W-1:0] random_word();
    logic [b7tcu_pkg::SHIFT_W-1:0] digits;
    int                            term_pct;
    case ($urandom_range(3))
      0: return $urandom();
      1: term_pct = 3;
      2: term_pct = 60;
      default: term_pct = $urandom_range(100);
    endcase
    for (int k = 0; k < b7tcu_pkg::MAX_DIGITS; k++) begin
      digits[k*b7tcu_pkg::DIGIT_W +: b7tcu_pkg::DIGIT_W] =
        ($urandom_range(99) < term_pct) ? b7tcu_pkg::TERM_DIGIT :
                                          b7tcu_pkg::DIGIT_W'($urandom_range(BASE - 1));
    end
    return digits[b7tcu_pkg::WORD_W-1:0];
  endfunction

  // Main sequence: reset, directed words, then four idling phases.
  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab  = '{0, 49, 0, 37};
    stall_tab = '{0, 0, 49, 37};
    board = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // All terminators in each phase, then long zero runs that wrap the sum.
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'o76543210, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    // Terminators that straddle the word boundaries of a group.
    send_word(32'hC000_0000, 1'b0);
    send_word(32'h8000_0001, 1'b0);
    send_word(32'h0000_0003, 1'b0);
    // Final-word flag in every phase; the first three each drop a partial number.
    send_word(32'h1234_5678, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_000F, 1'b1);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h0000_0000, 1'b0);
    send_word(32'h89AB_CDEF, 1'b1);
    send_word(32'o07654321, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b1);
    drain(idle_tab[0], stall_tab[0]);

    for (int ph = 0; ph < 4; ph++) begin
      for (int n = 0; n < RAND_WORDS; n++) begin
        send_word(random_word(), ($urandom_range(99) < LAST_PCT));
      end
      drain(idle_tab[(ph + 1) % 4], stall_tab[(ph + 1) % 4]);
    end

    repeat (SETTLE_CYC) @(posedge clk);
    if (board.errors == 0) begin
      $display("PASS base7_terminated_code_unpacker");
    end else begin
      $display("FAIL base7_terminated_code_unpacker");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL base7_terminated_code_unpacker");
    $finish;
  end

endmodule

// File: files.f
rtl/core/b7tcu_pkg.sv
rtl/core/b7tcu_digit_shifter.sv
rtl/core/b7tcu_accum.sv
rtl/core/base7_terminated_code_unpacker.sv
bench/tb_base7_terminated_code_unpacker.sv
